// ===== hw/rtl/swt_pkg.sv =====
// Shared types and constants for the sleeper wakeup table.
// No dependencies; used by swt_out_stage and sleeper_wakeup_table_core.
`timescale 1ns / 1ps

package swt_pkg;

  // Field widths fixed by the item format
  localparam int TIME_W = 63;
  localparam int ID_W   = 8;
  localparam int EV_W   = 3;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Input kind
  localparam logic KIND_SLEEP = 1'b0;

  // Result event codes
  localparam logic [EV_W-1:0] EV_SLEEP_OK = 3'd0;
  localparam logic [EV_W-1:0] EV_IDLE     = 3'd1;
  localparam logic [EV_W-1:0] EV_FULL     = 3'd2;
  localparam logic [EV_W-1:0] EV_WOKEN    = 3'd3;
  localparam logic [EV_W-1:0] EV_DONE     = 3'd4;

  // One result beat
  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wake;
    logic              last;
  } result_t;

endpackage

// ===== hw/rtl/swt_out_stage.sv =====
// Output holding register for result beats, with valid/ready handshake.
// Depends on swt_pkg (result_t, field widths).
`timescale 1ns / 1ps

module swt_out_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  swt_pkg::result_t             res,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swt_pkg::EV_W-1:0]     event_res,
  output logic [swt_pkg::ID_W-1:0]     woken_id,
  output logic [swt_pkg::TIME_W-1:0]   next_wake,
  output logic                         last
);
  import swt_pkg::*;

  result_t held;

  // Register can take a new beat when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign event_res = held.ev;
  assign woken_id  = held.id;
  assign next_wake = held.wake;
  assign last      = held.last;

endmodule

// ===== hw/rtl/sleeper_wakeup_table_core.sv =====
// Sleeper wakeup table: entry memory, woken-id buffer and control sequencer.
// Depends on swt_pkg and swt_out_stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_ready  | kind, thread_id, tick_value,
//          |           |                      | requester_is_idle
//  out     | output    | out_valid / out_ready| event_res, woken_id, next_wake, last
//
// A sleep beat's single result is loaded into the output register at acceptance.
// A tick beat with N occupied slots and W woken threads makes one pass over the entry
// memory (one read port, one slot a cycle), then the fetch state, then W results from
// the woken-id buffer and a done result, one a cycle unless the output stalls.
// Reset (rst, synchronous) empties the table and sets the earliest wake to zero.
// A stalled output holds the drain state in place and keeps in_ready low; no new item is
// taken until a tick's closing result has been loaded.
`timescale 1ns / 1ps

module sleeper_wakeup_table_core #(
  parameter int SLOTS   = swt_pkg::SLOTS_DEF,
  parameter int ID_BITS = swt_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [swt_pkg::ID_W-1:0]     thread_id,
  input  logic [swt_pkg::TIME_W-1:0]   tick_value,
  input  logic                         requester_is_idle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swt_pkg::EV_W-1:0]     event_res,
  output logic [swt_pkg::ID_W-1:0]     woken_id,
  output logic [swt_pkg::TIME_W-1:0]   next_wake,
  output logic                         last
);
  import swt_pkg::*;

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int IdW  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [CntW-1:0] SlotsC = CntW'(SLOTS);

  typedef struct packed {
    logic [IdW-1:0]    tid;
    logic [TIME_W-1:0] wake;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CntW-1:0]   count, count_next;
  logic [TIME_W-1:0] earliest, earliest_next;
  logic [TIME_W-1:0] tick_now, tick_now_next;
  logic [IdxW-1:0]   scan_i, scan_i_next;
  logic [CntW-1:0]   keep, keep_next;
  logic [CntW-1:0]   nwoken, nwoken_next;
  logic [CntW-1:0]   drain_j, drain_j_next;

  // Memories and their ports
  entry_t          ent_mem [SLOTS];
  entry_t          ent_rd;
  entry_t          ent_wdata;
  logic            ent_we;
  logic [IdxW-1:0] ent_waddr, ent_raddr;

  logic [IdW-1:0]  wk_mem [SLOTS];
  logic [IdW-1:0]  wk_rd;
  logic [IdW-1:0]  wk_wdata;
  logic            wk_we;
  logic [IdxW-1:0] wk_waddr, wk_raddr;

  logic    out_free;
  logic    res_load;
  result_t res;
  logic    accept;
  logic    is_woken;
  logic    last_scan;

  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign is_woken  = (ent_rd.wake <= tick_now);
  assign last_scan = ((CntW'(scan_i) + CntW'(1)) == count);

  // Sequencer and datapath control
  always_comb begin
    state_next    = state;
    count_next    = count;
    earliest_next = earliest;
    tick_now_next = tick_now;
    scan_i_next   = scan_i;
    keep_next     = keep;
    nwoken_next   = nwoken;
    drain_j_next  = drain_j;

    ent_we    = 1'b0;
    ent_waddr = count[IdxW-1:0];
    ent_wdata = '{tid: thread_id[IdW-1:0], wake: tick_value};
    ent_raddr = '0;

    wk_we     = 1'b0;
    wk_waddr  = nwoken[IdxW-1:0];
    wk_wdata  = ent_rd.tid;
    wk_raddr  = drain_j[IdxW-1:0];

    res_load  = 1'b0;
    res       = '{ev: EV_SLEEP_OK, id: '0, wake: earliest, last: 1'b0};

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == KIND_SLEEP) begin
            res_load = 1'b1;
            res.last = 1'b1;
            if (requester_is_idle) begin
              res.ev = EV_IDLE;
            end else if (count == SlotsC) begin
              res.ev = EV_FULL;
            end else begin
              ent_we     = 1'b1;
              count_next = count + CntW'(1);
              if (tick_value < earliest) begin
                earliest_next = tick_value;
              end
              res.id   = ID_W'(thread_id[IdW-1:0]);
              res.wake = earliest_next;
            end
          end else begin
            // Tick: first read of slot 0 goes out now
            tick_now_next = tick_value;
            earliest_next = TIME_MAX;
            scan_i_next   = '0;
            keep_next     = '0;
            nwoken_next   = '0;
            drain_j_next  = '0;
            state_next    = (count == '0) ? ST_FETCH : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Read ahead one slot; compaction writes land at or below the current slot
        ent_raddr   = IdxW'(CntW'(scan_i) + CntW'(1));
        scan_i_next = IdxW'(CntW'(scan_i) + CntW'(1));
        if (is_woken) begin
          wk_we       = 1'b1;
          nwoken_next = nwoken + CntW'(1);
        end else begin
          ent_we    = 1'b1;
          ent_waddr = keep[IdxW-1:0];
          ent_wdata = ent_rd;
          keep_next = keep + CntW'(1);
          if (ent_rd.wake < earliest) begin
            earliest_next = ent_rd.wake;
          end
        end
        if (last_scan) begin
          count_next = keep_next;
          state_next = ST_FETCH;
        end
      end

      ST_FETCH: begin
        // Woken buffer read of entry 0, after the last scan write has landed
        state_next = ST_DRAIN;
      end

      ST_DRAIN: begin
        if (out_free) begin
          res_load = 1'b1;
          if (drain_j != nwoken) begin
            res.ev       = EV_WOKEN;
            res.id       = ID_W'(wk_rd);
            drain_j_next = drain_j + CntW'(1);
            wk_raddr     = drain_j_next[IdxW-1:0];
          end else begin
            res.ev     = EV_DONE;
            res.last   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd <= ent_mem[ent_raddr];
  end

  // Woken-id buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    wk_rd <= wk_mem[wk_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      earliest <= '0;
      scan_i   <= '0;
      keep     <= '0;
      nwoken   <= '0;
      drain_j  <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      earliest <= earliest_next;
      scan_i   <= scan_i_next;
      keep     <= keep_next;
      nwoken   <= nwoken_next;
      drain_j  <= drain_j_next;
    end
  end

  // Current tick, payload only
  always_ff @(posedge clk) begin
    tick_now <= tick_now_next;
  end

  swt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .woken_id  (woken_id),
    .next_wake (next_wake),
    .last      (last)
  );

endmodule
